/* rtl/gesture_event_debouncer_macros.svh */
// Assertion macros shared by the gesture event debouncer RTL.
`ifndef GESTURE_EVENT_DEBOUNCER_MACROS_SVH
`define GESTURE_EVENT_DEBOUNCER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GEDB_ASSERT_SAME(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("gedb: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GEDB_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("gedb: next-cycle check failed");

`endif

/* rtl/gedb_pkg.sv */
// Types, codes and helper functions of the gesture event debouncer.
`default_nettype none

package gedb_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = 3;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [7:0]        flags_t;

  typedef enum logic [2:0] {
    ST_ACCEPT   = 3'd0,
    ST_DISABLED = 3'd1,
    ST_FIRST    = 3'd2,
    ST_NONE     = 3'd3,
    ST_COOLDOWN = 3'd4,
    ST_DEBOUNCE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_VOL_UP   = 3'd1,
    CMD_VOL_DOWN = 3'd2,
    CMD_STOP     = 3'd3,
    CMD_FORWARD  = 3'd4,
    CMD_BACKWARD = 3'd5,
    CMD_CW       = 3'd6,
    CMD_CCW      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_COOLDOWN = 2'd1,
    CFG_DEBOUNCE = 2'd2,
    CFG_ROTATION = 2'd3
  } cfg_idx_t;

  localparam flags_t FLAG_LEFT  = 8'h01;
  localparam flags_t FLAG_RIGHT = 8'h02;
  localparam flags_t FLAG_DOWN  = 8'h04;
  localparam flags_t FLAG_UP    = 8'h08;
  localparam flags_t FLAG_FWD   = 8'h10;
  localparam flags_t FLAG_BACK  = 8'h20;
  localparam flags_t FLAG_CW    = 8'h40;
  localparam flags_t FLAG_CCW   = 8'h80;

  localparam logic [15:0] COOLDOWN_RESET = 16'd1000;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd1000;

  typedef struct packed {
    logic        enabled;
    logic [15:0] cooldown_ms;
    logic [15:0] debounce_ms;
    logic [1:0]  rotation;
  } cfg_t;

  typedef struct packed {
    status_t status;
    cmd_t    command;
    slot_t   slot;
    logic    commit;
    logic    clear_first;
  } dec_t;

  // Masks for up, down, left, right in that order, index 3 is up.
  typedef flags_t [3:0] dir_masks_t;

  function automatic dir_masks_t rot_masks(logic [1:0] rot);
    dir_masks_t m;
    case (rot)
      2'd0:    m = {FLAG_UP,    FLAG_DOWN,  FLAG_LEFT,  FLAG_RIGHT};
      2'd1:    m = {FLAG_LEFT,  FLAG_RIGHT, FLAG_DOWN,  FLAG_UP};
      2'd2:    m = {FLAG_DOWN,  FLAG_UP,    FLAG_RIGHT, FLAG_LEFT};
      2'd3:    m = {FLAG_RIGHT, FLAG_LEFT,  FLAG_UP,    FLAG_DOWN};
      default: m = {FLAG_UP,    FLAG_DOWN,  FLAG_LEFT,  FLAG_RIGHT};
    endcase
    return m;
  endfunction

  // Position of the lowest set bit; an empty byte gives the top slot.
  function automatic slot_t lowest_bit(flags_t g);
    slot_t p;
    p = slot_t'(NUM_SLOTS - 1);
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (g[i]) p = slot_t'(i);
    end
    return p;
  endfunction

  function automatic cmd_t map_command(flags_t g, logic [1:0] rot);
    dir_masks_t m;
    cmd_t       c;
    m = rot_masks(rot);
    if      ((g & m[3]) != '0)    c = CMD_VOL_UP;
    else if ((g & m[2]) != '0)    c = CMD_VOL_DOWN;
    else if ((g & m[1]) != '0)    c = CMD_STOP;
    else if ((g & m[0]) != '0)    c = CMD_STOP;
    else if ((g & FLAG_FWD) != '0)  c = CMD_FORWARD;
    else if ((g & FLAG_BACK) != '0) c = CMD_BACKWARD;
    else if ((g & FLAG_CW) != '0)   c = CMD_CW;
    else if ((g & FLAG_CCW) != '0)  c = CMD_CCW;
    else                          c = CMD_NONE;
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/gedb_if.sv */
// Valid/ready channel interfaces for polls in and results out.
`default_nettype none

interface gedb_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  gesture_flags;
  logic [31:0] now_ms;

  modport source (output valid, output gesture_flags, output now_ms, input ready);
  modport sink   (input valid, input gesture_flags, input now_ms, output ready);
endinterface

interface gedb_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] command;
  logic [2:0] slot_index;

  modport source (output valid, output status, output command, output slot_index,
                  input ready);
  modport sink   (input valid, input status, input command, input slot_index,
                  output ready);
endinterface

`default_nettype wire

/* rtl/gedb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module gedb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/gedb_decide.sv */
// Poll classification: enable, first poll, empty poll, cooldown and debounce checks.
`default_nettype none

module gedb_decide import gedb_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  wire cfg_t                 cfg,
  input  wire logic                 first_pending,
  input  wire flags_t               flags,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic [TIME_BITS-1:0] last_any,
  input  wire logic [TIME_BITS-1:0] slot_time,
  output      dec_t                 dec
);

  logic [TIME_BITS-1:0] diff_any;
  logic [TIME_BITS-1:0] diff_slot;

  // Differences wrap modulo the time width, as the timestamps do.
  assign diff_any  = now - last_any;
  assign diff_slot = now - slot_time;

  always_comb begin
    dec = '{status: ST_NONE, command: CMD_NONE, slot: '0, commit: 1'b0,
            clear_first: 1'b0};
    if (!cfg.enabled) begin
      dec.status = ST_DISABLED;
    end else if (first_pending) begin
      dec.status      = ST_FIRST;
      dec.clear_first = 1'b1;
    end else if (flags == '0) begin
      dec.status = ST_NONE;
    end else begin
      dec.slot = lowest_bit(flags);
      if (diff_any < TIME_BITS'(cfg.cooldown_ms)) begin
        dec.status = ST_COOLDOWN;
      end else if (diff_slot < TIME_BITS'(cfg.debounce_ms)) begin
        dec.status = ST_DEBOUNCE;
      end else begin
        dec.status  = ST_ACCEPT;
        dec.commit  = 1'b1;
        dec.command = map_command(flags, cfg.rotation);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/gesture_event_debouncer.sv */
// Top level of the gesture event debouncer: channels, slot-time memory, state.
// A poll beat that is taken waits in stage one and enters the output register when that
// register is free, so a stalled output channel holds it in stage one.
// Throughput: one poll per cycle unless the output stalls; the slot-time memory does one
// read-modify-write per cycle, with one poll's write forwarded to the next poll's read.
// Reset (synchronous, rst_n low): configuration returns to disabled, 1000 ms limits and no
// rotation; the first-poll flag is set, all stored times read as zero, no beat is pending.
`default_nettype none

`include "gesture_event_debouncer_macros.svh"

module gesture_event_debouncer import gedb_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  gedb_in_if.sink          in_ch,
  gedb_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  // Configuration registers.
  cfg_t cfg_r;

  // Stage one holds an accepted poll while its slot time is read from memory.
  logic                 s1_valid_r;
  flags_t               s1_flags_r;
  logic [TIME_BITS-1:0] s1_now_r;
  slot_t                s1_slot_r;

  // Block state. Slot times live in the RAM; a valid bit per slot stands in for the
  // reset value, so a slot never written reads as time zero.
  logic                 first_pending_r;
  logic [TIME_BITS-1:0] last_any_r;
  logic [NUM_SLOTS-1:0] slot_valid_r;

  // Forwarding: the previous poll wrote the slot that the current one read in the
  // same cycle, so the RAM read data is stale and this copy is used instead.
  logic                 fwd_hit_r;
  logic [TIME_BITS-1:0] fwd_time_r;

  // Output register.
  logic    out_valid_r;
  status_t out_status_r;
  cmd_t    out_command_r;
  slot_t   out_slot_r;

  logic                 in_fire;
  logic                 out_free;
  logic                 s1_retire;
  slot_t                in_slot;
  logic [TIME_BITS-1:0] ram_rdata;
  logic [TIME_BITS-1:0] slot_time;
  logic                 ram_we;
  slot_t                ram_waddr;
  dec_t                 dec;

  assign in_slot   = lowest_bit(in_ch.gesture_flags);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign s1_retire = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || s1_retire;
  assign in_fire   = in_ch.valid && in_ch.ready;

  // Memory write happens as the poll in stage one retires into the output register.
  assign ram_we    = s1_retire && dec.commit;
  assign ram_waddr = dec.slot;

  gedb_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s1_now_r),
    .re    (in_fire),
    .raddr (in_slot),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (fwd_hit_r) begin
      slot_time = fwd_time_r;
    end else if (slot_valid_r[s1_slot_r]) begin
      slot_time = ram_rdata;
    end else begin
      slot_time = '0;
    end
  end

  gedb_decide #(
    .TIME_BITS (TIME_BITS)
  ) u_decide (
    .cfg           (cfg_r),
    .first_pending (first_pending_r),
    .flags         (s1_flags_r),
    .now           (s1_now_r),
    .last_any      (last_any_r),
    .slot_time     (slot_time),
    .dec           (dec)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{enabled: 1'b0, cooldown_ms: COOLDOWN_RESET,
                 debounce_ms: DEBOUNCE_RESET, rotation: 2'd0};
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:   cfg_r.enabled     <= cfg_wdata[0];
        CFG_COOLDOWN: cfg_r.cooldown_ms <= cfg_wdata;
        CFG_DEBOUNCE: cfg_r.debounce_ms <= cfg_wdata;
        CFG_ROTATION: cfg_r.rotation    <= cfg_wdata[1:0];
        default:      cfg_r             <= cfg_r;
      endcase
    end
  end

  // Control state and block state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      first_pending_r <= 1'b1;
      last_any_r      <= '0;
      slot_valid_r    <= '0;
      fwd_hit_r       <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= ram_we && (ram_waddr == in_slot);
      end else if (s1_retire) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_retire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (s1_retire && dec.clear_first) begin
        first_pending_r <= 1'b0;
      end

      if (ram_we) begin
        last_any_r              <= s1_now_r;
        slot_valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_flags_r <= in_ch.gesture_flags;
      s1_now_r   <= TIME_BITS'(in_ch.now_ms);
      s1_slot_r  <= in_slot;
      fwd_time_r <= s1_now_r;
    end
    if (s1_retire) begin
      out_status_r  <= dec.status;
      out_command_r <= dec.command;
      out_slot_r    <= dec.slot;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.command    = out_command_r;
  assign out_ch.slot_index = out_slot_r;

  // A committed gesture shows up as an accepted beat in the next cycle.
  `GEDB_ASSERT_NEXT(a_commit_gives_accept, ram_we, out_valid_r && out_status_r == ST_ACCEPT)
  // The first-poll flag never comes back once cleared, short of reset.
  `GEDB_ASSERT_NEXT(a_first_stays_clear, !first_pending_r, !first_pending_r)
  // Every slot write marks its slot as holding a real time.
  `GEDB_ASSERT_NEXT(a_write_sets_valid, ram_we, slot_valid_r[$past(ram_waddr)])
  // Rejected gestures carry no command.
  `GEDB_ASSERT_SAME(a_reject_no_cmd,
    out_valid_r && (out_status_r == ST_COOLDOWN || out_status_r == ST_DEBOUNCE),
    out_command_r == CMD_NONE)

endmodule

`default_nettype wire
